[sv/grid_divergence_curl_stencil_unit_assert.svh]
// ----------------------------------------------------------------------------
// grid_divergence_curl_stencil_unit_assert.svh
// Assertion macros for the stencil unit. They compile to nothing when SYNTH is
// defined.
// ----------------------------------------------------------------------------
`ifndef GRID_DIVERGENCE_CURL_STENCIL_UNIT_ASSERT_SVH
`define GRID_DIVERGENCE_CURL_STENCIL_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge out of reset.
`define GDCS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define GDCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GDCS_ASSERT_IMP(label, ante, cons)
`define GDCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/gdcs_pkg.sv]
// ----------------------------------------------------------------------------
// gdcs_pkg
// Shared constants, types and arithmetic helpers of the stencil unit.
// ----------------------------------------------------------------------------
package gdcs_pkg;

	// Grid and component geometry.
	localparam int AXIS_BITS       = 5;
	localparam int COMPONENT_WIDTH = 32;
	localparam int AXIS_CELLS      = 1 << AXIS_BITS;
	localparam int ADDR_W          = 3 * AXIS_BITS;
	localparam int CELL_COUNT      = 1 << ADDR_W;
	localparam int VEC_W           = 3 * COMPONENT_WIDTH;

	// Configuration port.
	localparam int SIZE_W     = 6;
	localparam int SCALE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(32);
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32768);

	// Width used to compare indices against a clipped size.
	localparam int CMP_W = (SIZE_W > AXIS_BITS + 1) ? SIZE_W : AXIS_BITS + 1;

	// Arithmetic widths.
	localparam int DIFF_W    = COMPONENT_WIDTH + 1;
	localparam int PROD_W    = DIFF_W + SCALE_W + 1;
	localparam int FRAC_BITS = 16;
	localparam int TERM_W    = PROD_W - FRAC_BITS;
	localparam int CAP_BIT   = 60;
	localparam int CAP_W     = (TERM_W > CAP_BIT + 2) ? TERM_W : CAP_BIT + 2;
	localparam int ACC_W     = CAP_W + 2;

	localparam logic signed [CAP_W-1:0] TERM_CAP =
		{{(CAP_W-CAP_BIT-1){1'b0}}, 1'b1, {CAP_BIT{1'b0}}};
	localparam logic signed [CAP_W-1:0] TERM_CAP_NEG = -TERM_CAP;
	localparam logic signed [ACC_W-1:0] OUT_MAX =
		{{(ACC_W-COMPONENT_WIDTH+1){1'b0}}, {(COMPONENT_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_X  = 3'd0,
		CFG_SIZE_Y  = 3'd1,
		CFG_SIZE_Z  = 3'd2,
		CFG_SCALE_X = 3'd3,
		CFG_SCALE_Y = 3'd4,
		CFG_SCALE_Z = 3'd5
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Face neighbors in read order: each axis reads its low side first.
	typedef enum logic [2:0] {
		NB_LEFT,
		NB_RIGHT,
		NB_DOWN,
		NB_UP,
		NB_BACK,
		NB_FRONT
	} nbr_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	// A size above the grid acts as the full grid.
	function automatic logic [CMP_W-1:0] clip_size(input logic [SIZE_W-1:0] s);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(s);
		return (ext > CMP_W'(AXIS_CELLS)) ? CMP_W'(AXIS_CELLS) : ext;
	endfunction

	// Lower neighbor index, clamped at zero.
	function automatic logic [AXIS_BITS-1:0] step_dn(input logic [AXIS_BITS-1:0] i);
		return (i == '0) ? i : i - AXIS_BITS'(1);
	endfunction

	// Upper neighbor index, clamped at the last cell in use.
	function automatic logic [AXIS_BITS-1:0] step_up(input logic [AXIS_BITS-1:0] i,
			input logic [CMP_W-1:0] n);
		return (CMP_W'(i) + CMP_W'(1) < n) ? i + AXIS_BITS'(1) : i;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [AXIS_BITS-1:0] x,
			input logic [AXIS_BITS-1:0] y, input logic [AXIS_BITS-1:0] z);
		return {z, y, x};
	endfunction

	// Memory address of one face neighbor of cell (i, j, k).
	function automatic logic [ADDR_W-1:0] nbr_addr(input nbr_t nb,
			input logic [AXIS_BITS-1:0] i, input logic [AXIS_BITS-1:0] j,
			input logic [AXIS_BITS-1:0] k, input logic [CMP_W-1:0] nx,
			input logic [CMP_W-1:0] ny, input logic [CMP_W-1:0] nz);
		logic [ADDR_W-1:0] a;
		case (nb)
			NB_LEFT:  a = cell_addr(step_dn(i), j, k);
			NB_RIGHT: a = cell_addr(step_up(i, nx), j, k);
			NB_DOWN:  a = cell_addr(i, step_dn(j), k);
			NB_UP:    a = cell_addr(i, step_up(j, ny), k);
			NB_BACK:  a = cell_addr(i, j, step_dn(k));
			NB_FRONT: a = cell_addr(i, j, step_up(k, nz));
			default:  a = cell_addr(i, j, k);
		endcase
		return a;
	endfunction

	// Floor of the product over 2^16, magnitude capped at 2^60.
	function automatic logic signed [CAP_W-1:0] cap_term(
			input logic signed [PROD_W-1:0] p);
		logic signed [CAP_W-1:0] t;
		t = CAP_W'(p >>> FRAC_BITS);
		if (t > TERM_CAP) begin
			t = TERM_CAP;
		end else if (t < TERM_CAP_NEG) begin
			t = TERM_CAP_NEG;
		end
		return t;
	endfunction

	// Saturate an exact sum to the signed component range.
	function automatic logic [COMPONENT_WIDTH-1:0] sat_out(
			input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > OUT_MAX) begin
			c = OUT_MAX;
		end else if (v < OUT_MIN) begin
			c = OUT_MIN;
		end
		return c[COMPONENT_WIDTH-1:0];
	endfunction

endpackage

[sv/grid_divergence_curl_stencil_unit.sv]
// ----------------------------------------------------------------------------
// grid_divergence_curl_stencil_unit
// Vector grid store with central-difference divergence and curl queries.
// ----------------------------------------------------------------------------
// A write transfer stores one cell, and the next transfer may follow at
// once. For a query, the six face neighbors come out of the single-port
// grid memory one per cycle, the first in its transfer cycle; a drain state
// finishes the multiply and the sum, and the finishing state loads the
// output register. A query outside the configured size goes straight to
// the finishing state for its flagged zero result. Input is stalled while a
// query is in progress, and a query waits in its finishing state while the
// previous result has not been taken. Writes are taken while a result waits.
`include "grid_divergence_curl_stencil_unit_assert.svh"

module grid_divergence_curl_stencil_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration
	input  logic                                   cfg_we,
	input  logic [gdcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gdcs_pkg::CFG_DATA_W-1:0]        cfg_data,
	// Input items
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   action,
	input  logic [gdcs_pkg::AXIS_BITS-1:0]         cell_x,
	input  logic [gdcs_pkg::AXIS_BITS-1:0]         cell_y,
	input  logic [gdcs_pkg::AXIS_BITS-1:0]         cell_z,
	input  logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] value_x,
	input  logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] value_y,
	input  logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] value_z,
	// Results
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] divergence,
	output logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] curl_x,
	output logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] curl_y,
	output logic signed [gdcs_pkg::COMPONENT_WIDTH-1:0] curl_z,
	output logic                                   bad_cell
);

	import gdcs_pkg::*;

	localparam int CW = COMPONENT_WIDTH;

	// Configuration registers.
	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;
	logic [CMP_W-1:0]   nx, ny, nz;

	// Sequencer.
	state_t state_q, state_d;
	nbr_t   rd_cnt_q, rd_nbr;
	logic   drain_q;
	logic   in_accept, in_inside, out_load;

	// Query cell.
	logic [AXIS_BITS-1:0] cell_x_q, cell_y_q, cell_z_q;
	logic                 bad_q;

	// Memory port.
	logic              ram_en, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [VEC_W-1:0]  ram_wdata, ram_rdata;

	// Read data stage and multiply stage.
	logic              rd_vld_s1;
	nbr_t              nbr_s1;
	logic [VEC_W-1:0]  lo_q;
	logic              pair_hi;
	axis_t             pair_axis;
	logic [SCALE_W-1:0] pair_scale;
	logic signed [DIFF_W-1:0] diff [3];
	logic signed [PROD_W-1:0] prod_s2 [3];
	logic              mul_vld_s2;
	axis_t             axis_s2;
	logic signed [ACC_W-1:0] term [3];

	// Accumulators.
	logic signed [ACC_W-1:0] acc_div_q, acc_cx_q, acc_cy_q, acc_cz_q;

	// Result register.
	logic          out_valid_q;
	logic [CW-1:0] divergence_q, curl_x_q, curl_y_q, curl_z_q;
	logic          bad_cell_q;

	assign nx = clip_size(size_x_q);
	assign ny = clip_size(size_y_q);
	assign nz = clip_size(size_z_q);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign in_inside = (CMP_W'(cell_x) < nx) && (CMP_W'(cell_y) < ny) && (CMP_W'(cell_z) < nz);
	assign ram_wdata = {value_z, value_y, value_x};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= SIZE_RESET;
			size_y_q  <= SIZE_RESET;
			size_z_q  <= SIZE_RESET;
			scale_x_q <= SCALE_RESET;
			scale_y_q <= SCALE_RESET;
			scale_z_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE_X:  size_x_q  <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Y:  size_y_q  <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Z:  size_z_q  <= cfg_data[SIZE_W-1:0];
				CFG_SCALE_X: scale_x_q <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_Y: scale_y_q <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_Z: scale_z_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control. The left neighbor read of a query
	// is issued in its transfer cycle, straight from the input indices.
	always_comb begin
		state_d  = state_q;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = cell_addr(cell_x, cell_y, cell_z);
		rd_nbr   = rd_cnt_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_nbr = NB_LEFT;
				if (in_accept) begin
					if (!action) begin
						ram_en = in_inside;
						ram_we = in_inside;
					end else if (in_inside) begin
						ram_en   = 1'b1;
						ram_addr = nbr_addr(NB_LEFT, cell_x, cell_y, cell_z, nx, ny, nz);
						state_d  = ST_READ;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_READ: begin
				ram_en   = 1'b1;
				ram_addr = nbr_addr(rd_cnt_q, cell_x_q, cell_y_q, cell_z_q, nx, ny, nz);
				if (rd_cnt_q == NB_FRONT) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer counters and read pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q   <= NB_LEFT;
			drain_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				rd_cnt_q <= NB_RIGHT;
			end else if (state_q == ST_READ) begin
				rd_cnt_q <= nbr_t'(rd_cnt_q + 3'd1);
			end
			drain_q    <= (state_q == ST_DRAIN) ? !drain_q : 1'b0;
			rd_vld_s1  <= ram_en && !ram_we;
			mul_vld_s2 <= rd_vld_s1 && pair_hi;
		end
	end

	// Query cell and neighbor tag.
	always_ff @(posedge clk) begin
		if (in_accept && action) begin
			cell_x_q <= cell_x;
			cell_y_q <= cell_y;
			cell_z_q <= cell_z;
		end
		nbr_s1 <= rd_nbr;
	end

	// The upper neighbor of each axis closes a pair; pick its spacing factor.
	always_comb begin
		pair_hi    = 1'b0;
		pair_axis  = AXIS_X;
		pair_scale = scale_x_q;
		case (nbr_s1)
			NB_RIGHT: begin
				pair_hi    = 1'b1;
				pair_axis  = AXIS_X;
				pair_scale = scale_x_q;
			end
			NB_UP: begin
				pair_hi    = 1'b1;
				pair_axis  = AXIS_Y;
				pair_scale = scale_y_q;
			end
			NB_FRONT: begin
				pair_hi    = 1'b1;
				pair_axis  = AXIS_Z;
				pair_scale = scale_z_q;
			end
			default: ;
		endcase
	end

	// Exact differences of the pair, one per component.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c] = $signed({ram_rdata[c*CW+CW-1], ram_rdata[c*CW +: CW]})
				- $signed({lo_q[c*CW+CW-1], lo_q[c*CW +: CW]});
		end
	end

	// Hold the low neighbor, then multiply the three differences of the pair.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !pair_hi) begin
			lo_q <= ram_rdata;
		end
		if (rd_vld_s1 && pair_hi) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= diff[c] * $signed({1'b0, pair_scale});
			end
			axis_s2 <= pair_axis;
		end
	end

	// Rounded and capped terms, widened for the sums.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			term[c] = ACC_W'(cap_term(prod_s2[c]));
		end
	end

	// Add each term where it belongs: the matching component goes to the
	// divergence, the two others to the curl with the right sign.
	always_ff @(posedge clk) begin
		if (in_accept && action) begin
			acc_div_q <= '0;
			acc_cx_q  <= '0;
			acc_cy_q  <= '0;
			acc_cz_q  <= '0;
			bad_q     <= !in_inside;
		end else if (mul_vld_s2) begin
			case (axis_s2)
				AXIS_X: begin
					acc_div_q <= acc_div_q + term[0];
					acc_cz_q  <= acc_cz_q + term[1];
					acc_cy_q  <= acc_cy_q - term[2];
				end
				AXIS_Y: begin
					acc_cz_q  <= acc_cz_q - term[0];
					acc_div_q <= acc_div_q + term[1];
					acc_cx_q  <= acc_cx_q + term[2];
				end
				AXIS_Z: begin
					acc_cy_q  <= acc_cy_q + term[0];
					acc_cx_q  <= acc_cx_q - term[1];
					acc_div_q <= acc_div_q + term[2];
				end
				default: ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			divergence_q <= sat_out(acc_div_q);
			curl_x_q     <= sat_out(acc_cx_q);
			curl_y_q     <= sat_out(acc_cy_q);
			curl_z_q     <= sat_out(acc_cz_q);
			bad_cell_q   <= bad_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign divergence = divergence_q;
	assign curl_x     = curl_x_q;
	assign curl_y     = curl_y_q;
	assign curl_z     = curl_z_q;
	assign bad_cell   = bad_cell_q;

	// Grid memory.
	gdcs_ram #(
		.WIDTH(VEC_W),
		.DEPTH(CELL_COUNT)
	) u_grid_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// A query transfer always occupies the block for the following cycle.
	`GDCS_ASSERT_NEXT(query_holds_input_a, in_valid && !in_stall && action, in_stall)
	// A new result only appears after the finishing cycle of a query.
	`GDCS_ASSERT_IMP(result_from_finish_a, $rose(out_valid), $past(state_q) == ST_FINISH)
	// Products are only summed while a query is still reading or draining.
	`GDCS_ASSERT_IMP(mul_in_query_a, mul_vld_s2, state_q == ST_READ || state_q == ST_DRAIN)
	// The read and multiply stages are empty when a result is loaded.
	`GDCS_ASSERT_IMP(drained_at_finish_a, state_q == ST_FINISH, !rd_vld_s1 && !mul_vld_s2)

endmodule

[sv/gdcs_ram.sv]
// ----------------------------------------------------------------------------
// gdcs_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module gdcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a write, or a read whose data appears next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[sim/grid_divergence_curl_stencil_unit_tb.sv]
// ----------------------------------------------------------------------------
// grid_divergence_curl_stencil_unit_tb
// Self-checking bench for the vector grid stencil unit. A scoreboard keeps
// its own copy of the grid and the registers, predicts the divergence and
// curl of every accepted query, and compares each result transfer in order.
// Stimulus is a directed opening followed by random write and query streams
// under several grid sizes and scale factors, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module grid_divergence_curl_stencil_unit_tb;
	import gdcs_pkg::*;

	localparam int CW = COMPONENT_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = DW + SCALE_W + 1;
	localparam int SW = PW + 2;
	localparam int SHIFT_BITS = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 75;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [CW-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [CW-1:0] Q_MIN = 32'h8000_0000;
	localparam logic signed [PW-1:0] TERM_LIMIT = {{(PW-61){1'b0}}, 1'b1, 60'd0};
	localparam logic signed [SW-1:0] OUT_TOP = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] OUT_BOTTOM = ~OUT_TOP;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef struct {
		action_t               action;
		logic [AXIS_BITS-1:0]  cell_x;
		logic [AXIS_BITS-1:0]  cell_y;
		logic [AXIS_BITS-1:0]  cell_z;
		logic signed [CW-1:0]  value_x;
		logic signed [CW-1:0]  value_y;
		logic signed [CW-1:0]  value_z;
	} stencil_item_t;

	typedef struct {
		logic signed [CW-1:0] divergence;
		logic signed [CW-1:0] curl_x;
		logic signed [CW-1:0] curl_y;
		logic signed [CW-1:0] curl_z;
		logic                 bad_cell;
	} stencil_result_t;

	// Scoreboard: mirror of the grid and registers, and the queue of results
	// that accepted queries still owe.
	class stencil_scoreboard;
		logic signed [CW-1:0] vec [CELL_COUNT][3];
		bit                   written [CELL_COUNT];
		logic [SIZE_W-1:0]    size_reg [3];
		logic [SCALE_W-1:0]   scale_reg [3];
		stencil_result_t      owed_q [$];
		int                   error_count;

		function new();
			for (int a = 0; a < 3; a++) begin
				size_reg[a] = SIZE_RESET;
				scale_reg[a] = SCALE_RESET;
			end
			foreach (written[c]) written[c] = 1'b0;
			error_count = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SIZE_X:  size_reg[0] = data[SIZE_W-1:0];
				CFG_SIZE_Y:  size_reg[1] = data[SIZE_W-1:0];
				CFG_SIZE_Z:  size_reg[2] = data[SIZE_W-1:0];
				CFG_SCALE_X: scale_reg[0] = data[SCALE_W-1:0];
				CFG_SCALE_Y: scale_reg[1] = data[SCALE_W-1:0];
				CFG_SCALE_Z: scale_reg[2] = data[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		// A size above the grid behaves as the full grid.
		function int axis_span(int axis);
			return (size_reg[axis] > AXIS_CELLS) ? AXIS_CELLS : int'(size_reg[axis]);
		endfunction

		function bit in_bounds(int x, int y, int z);
			return x < axis_span(0) && y < axis_span(1) && z < axis_span(2);
		endfunction

		// Face neighbor address, clamped to the edge of the cells in use.
		function logic [ADDR_W-1:0] neighbor_addr(nbr_t nb, int x, int y, int z);
			int i, j, k;
			i = x;
			j = y;
			k = z;
			case (nb)
				NB_LEFT:  if (i > 0) i--;
				NB_RIGHT: if (i + 1 < axis_span(0)) i++;
				NB_DOWN:  if (j > 0) j--;
				NB_UP:    if (j + 1 < axis_span(1)) j++;
				NB_BACK:  if (k > 0) k--;
				NB_FRONT: if (k + 1 < axis_span(2)) k++;
				default: ;
			endcase
			return {k[AXIS_BITS-1:0], j[AXIS_BITS-1:0], i[AXIS_BITS-1:0]};
		endfunction

		// Exact difference times the scale, floored over 2^16 and capped at 2^60.
		function logic signed [PW-1:0] diff_term(logic signed [CW-1:0] hi,
				logic signed [CW-1:0] lo, logic [SCALE_W-1:0] s);
			logic signed [DW-1:0] d;
			logic signed [PW-1:0] p;
			logic signed [PW-1:0] t;
			d = {hi[CW-1], hi} - {lo[CW-1], lo};
			p = $signed({{(PW-DW){d[DW-1]}}, d}) * $signed({{(PW-SCALE_W){1'b0}}, s});
			t = p >>> SHIFT_BITS;
			if (t > TERM_LIMIT) begin
				t = TERM_LIMIT;
			end else if (t < -TERM_LIMIT) begin
				t = -TERM_LIMIT;
			end
			return t;
		endfunction

		function logic signed [CW-1:0] clamp_out(logic signed [SW-1:0] v);
			if (v > OUT_TOP) begin
				return OUT_TOP[CW-1:0];
			end else if (v < OUT_BOTTOM) begin
				return OUT_BOTTOM[CW-1:0];
			end
			return v[CW-1:0];
		endfunction

		// Apply a write to the mirror, or predict the result of a query.
		function void note_input(stencil_item_t it);
			logic [ADDR_W-1:0] self;
			logic [ADDR_W-1:0] lf, rt, dn, up, bk, fr;
			logic signed [SW-1:0] acc;
			stencil_result_t r;
			self = {it.cell_z, it.cell_y, it.cell_x};
			if (it.action == ACT_WRITE) begin
				if (in_bounds(it.cell_x, it.cell_y, it.cell_z)) begin
					vec[self][0] = it.value_x;
					vec[self][1] = it.value_y;
					vec[self][2] = it.value_z;
					written[self] = 1'b1;
				end
			end else if (!in_bounds(it.cell_x, it.cell_y, it.cell_z)) begin
				r.divergence = '0;
				r.curl_x = '0;
				r.curl_y = '0;
				r.curl_z = '0;
				r.bad_cell = 1'b1;
				owed_q.push_back(r);
			end else begin
				lf = neighbor_addr(NB_LEFT, it.cell_x, it.cell_y, it.cell_z);
				rt = neighbor_addr(NB_RIGHT, it.cell_x, it.cell_y, it.cell_z);
				dn = neighbor_addr(NB_DOWN, it.cell_x, it.cell_y, it.cell_z);
				up = neighbor_addr(NB_UP, it.cell_x, it.cell_y, it.cell_z);
				bk = neighbor_addr(NB_BACK, it.cell_x, it.cell_y, it.cell_z);
				fr = neighbor_addr(NB_FRONT, it.cell_x, it.cell_y, it.cell_z);
				acc = diff_term(vec[rt][0], vec[lf][0], scale_reg[0])
					+ diff_term(vec[up][1], vec[dn][1], scale_reg[1])
					+ diff_term(vec[fr][2], vec[bk][2], scale_reg[2]);
				r.divergence = clamp_out(acc);
				acc = diff_term(vec[up][2], vec[dn][2], scale_reg[1])
					- diff_term(vec[fr][1], vec[bk][1], scale_reg[2]);
				r.curl_x = clamp_out(acc);
				acc = diff_term(vec[fr][0], vec[bk][0], scale_reg[2])
					- diff_term(vec[rt][2], vec[lf][2], scale_reg[0]);
				r.curl_y = clamp_out(acc);
				acc = diff_term(vec[rt][1], vec[lf][1], scale_reg[0])
					- diff_term(vec[up][0], vec[dn][0], scale_reg[1]);
				r.curl_z = clamp_out(acc);
				r.bad_cell = 1'b0;
				owed_q.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic signed [CW-1:0] want,
				logic signed [CW-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				error_count++;
			end
		endfunction

		// Compare one result transfer with the oldest owed result.
		function void check_result(stencil_result_t got);
			stencil_result_t want;
			if (owed_q.size() == 0) begin
				$error("result transfer with no query waiting for it");
				error_count++;
			end else begin
				want = owed_q.pop_front();
				compare_field("divergence", want.divergence, got.divergence);
				compare_field("curl_x", want.curl_x, got.curl_x);
				compare_field("curl_y", want.curl_y, got.curl_y);
				compare_field("curl_z", want.curl_z, got.curl_z);
				compare_field("bad_cell", CW'(want.bad_cell), CW'(got.bad_cell));
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    action;
	logic [AXIS_BITS-1:0]    cell_x;
	logic [AXIS_BITS-1:0]    cell_y;
	logic [AXIS_BITS-1:0]    cell_z;
	logic signed [CW-1:0]    value_x;
	logic signed [CW-1:0]    value_y;
	logic signed [CW-1:0]    value_z;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [CW-1:0]    divergence;
	logic signed [CW-1:0]    curl_x;
	logic signed [CW-1:0]    curl_y;
	logic signed [CW-1:0]    curl_z;
	logic                    bad_cell;

	stencil_scoreboard sb = new();
	bit                calm = 1'b0;
	int unsigned       cycle_count = 0;
	int                items_sent = 0;

	grid_divergence_curl_stencil_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_z     (cell_z),
		.value_x    (value_x),
		.value_y    (value_y),
		.value_z    (value_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.divergence (divergence),
		.curl_x     (curl_x),
		.curl_y     (curl_y),
		.curl_z     (curl_z),
		.bad_cell   (bad_cell)
	);

	// Clock with a period of four time units.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("grid_divergence_curl_stencil_unit_tb: done, errors");
			$finish;
		end
	end

	// Result monitor: every accepted result transfer is checked.
	always @(posedge clk) begin
		stencil_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.divergence = divergence;
			got.curl_x = curl_x;
			got.curl_y = curl_y;
			got.curl_z = curl_z;
			got.bad_cell = bad_cell;
			sb.check_result(got);
		end
	end

	// Receiver stalls in random bursts until the calm final stretch.
	initial begin
		int  span;
		bit  hold;
		out_stall = 1'b0;
		forever begin
			if (calm) begin
				@(negedge clk);
				out_stall = 1'b0;
			end else begin
				span = $urandom_range(1, 16);
				hold = ($urandom_range(0, 2) == 0);
				repeat (span) begin
					@(negedge clk);
					out_stall = hold;
				end
			end
		end
	end

	function automatic logic [CW-1:0] rand_component();
		logic [CW-1:0] v;
		case ($urandom_range(0, 4))
			0: v = Q_MIN;
			1: v = Q_MAX;
			2: v = $urandom_range(0, 32'h3FFFF) - 32'h20000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic stencil_item_t make_item(action_t act, int x, int y, int z,
			logic [CW-1:0] vx, logic [CW-1:0] vy, logic [CW-1:0] vz);
		stencil_item_t it;
		it.action = act;
		it.cell_x = x[AXIS_BITS-1:0];
		it.cell_y = y[AXIS_BITS-1:0];
		it.cell_z = z[AXIS_BITS-1:0];
		it.value_x = vx;
		it.value_y = vy;
		it.value_z = vz;
		return it;
	endfunction

	// Drive one input transfer, with an optional idle burst ahead of it.
	task automatic push_item(stencil_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		action = it.action;
		cell_x = it.cell_x;
		cell_y = it.cell_y;
		cell_z = it.cell_z;
		value_x = it.value_x;
		value_y = it.value_y;
		value_z = it.value_z;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic write_cell(int x, int y, int z, logic [CW-1:0] vx,
			logic [CW-1:0] vy, logic [CW-1:0] vz);
		push_item(make_item(ACT_WRITE, x, y, z, vx, vy, vz));
	endtask

	// Query a cell, first writing any neighbor that the query would read
	// and that holds no data yet.
	task automatic query_cell(int x, int y, int z);
		logic [ADDR_W-1:0] a;
		if (sb.in_bounds(x, y, z)) begin
			for (int n = 0; n < 6; n++) begin
				a = sb.neighbor_addr(nbr_t'(n), x, y, z);
				if (!sb.written[a]) begin
					write_cell(a[AXIS_BITS-1:0], a[2*AXIS_BITS-1:AXIS_BITS],
						a[3*AXIS_BITS-1:2*AXIS_BITS], rand_component(),
						rand_component(), rand_component());
				end
			end
		end
		push_item(make_item(ACT_QUERY, x, y, z, $urandom, $urandom, $urandom));
	endtask

	// Hold off the sender until every owed result has come, then let the
	// last writes settle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_register(idx, data);
	endtask

	// Size words carry random upper bits, which the block must ignore.
	function automatic logic [CFG_DATA_W-1:0] size_word(int s);
		return ($urandom & ~32'h3F) | CFG_DATA_W'(s[SIZE_W-1:0]);
	endfunction

	task automatic configure(int sx, int sy, int sz, logic [SCALE_W-1:0] kx,
			logic [SCALE_W-1:0] ky, logic [SCALE_W-1:0] kz);
		wait_drained();
		write_reg(CFG_SIZE_X, size_word(sx));
		write_reg(CFG_SIZE_Y, size_word(sy));
		write_reg(CFG_SIZE_Z, size_word(sz));
		write_reg(CFG_SCALE_X, kx);
		write_reg(CFG_SCALE_Y, ky);
		write_reg(CFG_SCALE_Z, kz);
	endtask

	function automatic int rand_size();
		int s;
		case ($urandom_range(0, 7))
			0, 1: s = $urandom_range(1, 4);
			2: s = $urandom_range(1, 8);
			3: s = AXIS_CELLS;
			4: s = $urandom_range(AXIS_CELLS + 1, 63);
			5: s = $urandom_range(0, 63);
			default: s = 1;
		endcase
		return s;
	endfunction

	function automatic logic [SCALE_W-1:0] rand_scale();
		logic [SCALE_W-1:0] k;
		case ($urandom_range(0, 4))
			0: k = '0;
			1: k = '1;
			2: k = SCALE_RESET;
			3: k = $urandom;
			default: k = $urandom_range(0, 32'h3FFFF);
		endcase
		return k;
	endfunction

	// Random stream: mostly writes and queries inside the grid in use, with
	// some writes and queries anywhere in the index range. Every transfer
	// counts toward the phase length, neighbor fills included.
	task automatic random_phase(int count);
		int first_item;
		int pick;
		int x, y, z;
		bit wild;
		first_item = items_sent;
		while (items_sent - first_item < count) begin
			pick = $urandom_range(0, 9);
			wild = (pick == 0) || sb.axis_span(0) == 0 || sb.axis_span(1) == 0
				|| sb.axis_span(2) == 0;
			if (wild) begin
				x = $urandom_range(0, AXIS_CELLS - 1);
				y = $urandom_range(0, AXIS_CELLS - 1);
				z = $urandom_range(0, AXIS_CELLS - 1);
			end else begin
				x = $urandom_range(0, sb.axis_span(0) - 1);
				y = $urandom_range(0, sb.axis_span(1) - 1);
				z = $urandom_range(0, sb.axis_span(2) - 1);
			end
			if ((wild && $urandom_range(0, 1) == 0) || (!wild && pick < 5)) begin
				write_cell(x, y, z, rand_component(), rand_component(), rand_component());
			end else begin
				query_cell(x, y, z);
			end
			if ($urandom_range(0, 39) == 0) wait_drained();
		end
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SIZE_X;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_WRITE;
		cell_x = '0;
		cell_y = '0;
		cell_z = '0;
		value_x = '0;
		value_y = '0;
		value_z = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: extreme components around the low corner drive the
		// divergence, curl_x and curl_z into saturation; the high corner checks edge clamping.
		write_cell(0, 0, 0, Q_MIN, Q_MAX, Q_MIN);
		write_cell(1, 0, 0, Q_MAX, Q_MIN, Q_MAX);
		write_cell(0, 1, 0, Q_MAX, Q_MAX, Q_MIN);
		write_cell(0, 0, 1, Q_MAX, Q_MIN, Q_MAX);
		query_cell(0, 0, 0);
		write_cell(31, 31, 31, Q_MAX, Q_MAX, Q_MAX);
		write_cell(30, 31, 31, Q_MIN, Q_MIN, Q_MIN);
		write_cell(31, 30, 31, Q_MIN, Q_MIN, Q_MIN);
		write_cell(31, 31, 30, Q_MIN, Q_MIN, Q_MIN);
		query_cell(31, 31, 31);
		write_cell(5, 6, 7, '0, '0, '0);
		query_cell(5, 6, 7);

		// Small grid: writes outside the size are dropped and queries outside
		// it come back flagged.
		configure(4, 3, 2, '1, '0, 32'h0000_0001);
		query_cell(3, 2, 1);
		write_cell(4, 0, 0, Q_MAX, Q_MAX, Q_MAX);
		write_cell(0, 3, 0, Q_MIN, Q_MIN, Q_MIN);
		query_cell(0, 0, 2);
		query_cell(31, 31, 31);
		query_cell(0, 0, 0);

		// Size zero, plus writes to the unused register indexes.
		configure(0, 0, 0, SCALE_RESET, SCALE_RESET, SCALE_RESET);
		write_reg(CFG_SPARE_A, $urandom);
		write_reg(CFG_SPARE_B, $urandom);
		write_cell(0, 0, 0, Q_MAX, Q_MAX, Q_MAX);
		query_cell(0, 0, 0);

		// Sizes above the grid act as the full grid.
		configure(63, 33, 32, $urandom, $urandom, $urandom);
		query_cell(31, 0, 31);
		query_cell(15, 31, 0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - 1) calm = 1'b1;
			configure(rand_size(), rand_size(), rand_size(), rand_scale(), rand_scale(),
				rand_scale());
			random_phase(PHASE_ITEMS);
		end

		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("grid_divergence_curl_stencil_unit_tb: done, clean");
		end else begin
			$display("grid_divergence_curl_stencil_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
